// ===== src/dtpc_pkg.sv =====
// Shared types, codes and constants of the depth to point cloud block.
package dtpc_pkg;

    // Register indexes of the configuration port
    typedef enum logic [2:0] {
        REG_IMAGE_WIDTH    = 3'd0,
        REG_DECIMATION     = 3'd1,
        REG_DEPTH_ENCODING = 3'd2,
        REG_CENTER_X       = 3'd3,
        REG_CENTER_Y       = 3'd4,
        REG_INV_FOCAL_X    = 3'd5,
        REG_INV_FOCAL_Y    = 3'd6,
        REG_FALLBACK_RGB   = 3'd7
    } dtpc_reg_t;

    // Depth encodings
    localparam logic [1:0] ENC_MM16    = 2'd0;
    localparam logic [1:0] ENC_FLOAT32 = 2'd1;

    // Port widths
    localparam int IN_TDATA_W  = 56;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 104;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 25;

    // Point queue depth between front and back
    localparam int QUEUE_DEPTH = 4;

    // Depth decoding constants
    localparam logic [9:0]  MM_PER_M     = 10'd1000;
    localparam logic [15:0] DEPTH_MIN_MM = 16'd10;
    localparam logic [15:0] DEPTH_MAX_MM = 16'hFFFF;
    localparam logic [7:0]  F32_EXP_INF  = 8'hFF;
    localparam logic [7:0]  F32_EXP_SAT  = 8'd150;   // at or above: always saturates
    localparam logic [7:0]  F32_EXP_LOW  = 8'd110;   // below: rounds to zero

    // Projection fixed point
    localparam int ROUND_SHIFT = 28;
    localparam int SPLIT_BITS  = 18;

    typedef struct packed {
        logic [12:0] image_width;
        logic [7:0]  decimation;
        logic [1:0]  depth_encoding;
        logic [15:0] center_x;
        logic [15:0] center_y;
        logic [24:0] inv_focal_x;
        logic [24:0] inv_focal_y;
        logic [23:0] fallback_rgb;
    } dtpc_cfg_t;

    localparam dtpc_cfg_t CFG_RESET = '{
        image_width:    13'd640,
        decimation:     8'd1,
        depth_encoding: ENC_MM16,
        center_x:       16'd5120,
        center_y:       16'd3840,
        inv_focal_x:    25'd0,
        inv_focal_y:    25'd0,
        fallback_rgb:   24'hFFFFFF
    };

    typedef struct packed {
        logic full;
        logic empty;
    } dtpc_qstat_t;

    // Back end sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAG,
        ST_MZ,
        ST_PL,
        ST_PH,
        ST_SUM,
        ST_FIN
    } dtpc_state_t;

endpackage

// ===== src/depth_to_point_cloud.sv =====
// Top level of the depth image to point cloud back-projection block.
//
//  Channel  Dir  Handshake            Payload (lowest bit up)
//  s_       in   s_tvalid/s_tready    tdata: depth_word, color_rgb; tuser: color_present,
//                                     frame_start
//  m_       out  m_tvalid/m_tready    tdata: point_x_mm, point_y_mm, point_z_mm, point_color
//  cfg_     in   cfg_valid/cfg_ready  cfg_index, cfg_data (always ready)
//
// The front end takes one pixel per clock but stalls while a point waits on a full queue.
// Each point goes through the back end as a pop plus six steps per coordinate through
// the one shared multiplier (mag*z, then the two halves of the product times 1/f).
// A four-entry queue lets the front run ahead while the back end or m_tready stalls.
// Reset is asynchronous: registers return to their defaults, counters to zero.
module depth_to_point_cloud #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [dtpc_pkg::IN_TDATA_W-1:0]     s_tdata,   // depth_word, color_rgb
    input  logic [dtpc_pkg::IN_TUSER_W-1:0]     s_tuser,   // color_present, frame_start
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [dtpc_pkg::OUT_TDATA_W-1:0]    m_tdata,   // x, y, z, colour
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [dtpc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [dtpc_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import dtpc_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int EW = CW + RW + 40;

    dtpc_cfg_t   cfg_reg;
    dtpc_qstat_t qstat;
    logic        push, pop;
    logic [EW-1:0] push_data, pop_data;
    logic [31:0] point_x_mm, point_y_mm;
    logic [15:0] point_z_mm;
    logic [23:0] point_color;

    assign cfg_ready = 1'b1;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (dtpc_reg_t'(cfg_index))
                REG_IMAGE_WIDTH:    cfg_reg.image_width    <= cfg_data[12:0];
                REG_DECIMATION:     cfg_reg.decimation     <= cfg_data[7:0];
                REG_DEPTH_ENCODING: cfg_reg.depth_encoding <= cfg_data[1:0];
                REG_CENTER_X:       cfg_reg.center_x       <= cfg_data[15:0];
                REG_CENTER_Y:       cfg_reg.center_y       <= cfg_data[15:0];
                REG_INV_FOCAL_X:    cfg_reg.inv_focal_x    <= cfg_data[24:0];
                REG_INV_FOCAL_Y:    cfg_reg.inv_focal_y    <= cfg_data[24:0];
                REG_FALLBACK_RGB:   cfg_reg.fallback_rgb   <= cfg_data[23:0];
                default: ;
            endcase
        end
    end

    dtpc_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .depth_word    (s_tdata[31:0]),
        .color_rgb     (s_tdata[55:32]),
        .color_present (s_tuser[0]),
        .frame_start   (s_tuser[1]),
        .push          (push),
        .push_data     (push_data),
        .qstat         (qstat)
    );

    dtpc_queue #(
        .WIDTH (EW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .qstat     (qstat)
    );

    dtpc_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .qstat       (qstat),
        .pop_data    (pop_data),
        .pop         (pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .point_x_mm  (point_x_mm),
        .point_y_mm  (point_y_mm),
        .point_z_mm  (point_z_mm),
        .point_color (point_color)
    );

    assign m_tdata = {point_color, point_z_mm, point_y_mm, point_x_mm};

endmodule

// ===== src/dtpc_front.sv =====
// Front end: pixel position counters, decimation, depth decoding and point classification.
module dtpc_front #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096,
    localparam int CW = $clog2(MAX_WIDTH),
    localparam int RW = $clog2(MAX_HEIGHT),
    localparam int EW = CW + RW + 40
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  dtpc_pkg::dtpc_cfg_t     cfg,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [31:0]             depth_word,
    input  logic [23:0]             color_rgb,
    input  logic                    color_present,
    input  logic                    frame_start,
    output logic                    push,
    output logic [EW-1:0]           push_data,
    input  dtpc_pkg::dtpc_qstat_t   qstat
);
    import dtpc_pkg::*;

    localparam int CMPW = ($clog2(MAX_WIDTH + 1) > 13) ? $clog2(MAX_WIDTH + 1) : 13;
    localparam int RCW  = $clog2(MAX_HEIGHT + 1);

    logic [CW-1:0]   col_reg, col_next, cur_col;
    logic [RW-1:0]   row_reg, row_next, cur_row;
    logic [7:0]      cph_reg, cph_next, cur_cph;
    logic [7:0]      rph_reg, rph_next, cur_rph;
    logic [CMPW-1:0] w_raw, w_eff, col_inc;
    logic [RCW-1:0]  row_inc;
    logic [7:0]      step;
    logic [8:0]      cph_inc, rph_inc;
    logic            row_end, in_acc, keep_in;
    logic [23:0]     mant24;

    logic            s1_valid_reg;
    logic            s1_keep_reg;
    logic            s1_float_reg;
    logic            s1_sign_reg;
    logic [7:0]      s1_exp_reg;
    logic [15:0]     s1_raw_reg;
    logic [33:0]     s1_m1000_reg;
    logic [CW-1:0]   s1_col_reg;
    logic [RW-1:0]   s1_row_reg;
    logic [23:0]     s1_color_reg;

    logic [5:0]      shamt;
    logic [33:0]     shifted;
    logic [34:0]     rounded;
    logic [15:0]     z_mm;
    logic            s1_point, s1_adv;

    // Position of this pixel, cleared on frame start
    always_comb
    begin
        cur_col = frame_start ? '0 : col_reg;
        cur_row = frame_start ? '0 : row_reg;
        cur_cph = frame_start ? '0 : cph_reg;
        cur_rph = frame_start ? '0 : rph_reg;
    end

    // Advance counters past this pixel
    always_comb
    begin
        w_raw   = (cfg.image_width == 13'd0) ? CMPW'(1) : CMPW'(cfg.image_width);
        w_eff   = (w_raw > CMPW'(MAX_WIDTH)) ? CMPW'(MAX_WIDTH) : w_raw;
        step    = (cfg.decimation == 8'd0) ? 8'd1 : cfg.decimation;
        col_inc = CMPW'(cur_col) + CMPW'(1);
        row_inc = RCW'(cur_row) + RCW'(1);
        cph_inc = {1'b0, cur_cph} + 9'd1;
        rph_inc = {1'b0, cur_rph} + 9'd1;
        row_end = (col_inc >= w_eff);
        if (row_end)
        begin
            col_next = '0;
            cph_next = '0;
            row_next = (row_inc >= RCW'(MAX_HEIGHT)) ? '0 : row_inc[RW-1:0];
            rph_next = (rph_inc >= {1'b0, step}) ? 8'd0 : rph_inc[7:0];
        end
        else
        begin
            col_next = col_inc[CW-1:0];
            cph_next = (cph_inc >= {1'b0, step}) ? 8'd0 : cph_inc[7:0];
            row_next = cur_row;
            rph_next = cur_rph;
        end
    end

    // Classify the incoming item
    always_comb
    begin
        in_acc  = in_valid && in_ready;
        mant24  = {(depth_word[30:23] != 8'd0), depth_word[22:0]};
        keep_in = (cur_cph == 8'd0) && (cur_rph == 8'd0)
                  && (cfg.inv_focal_x != 25'd0) && (cfg.inv_focal_y != 25'd0)
                  && ((cfg.depth_encoding == ENC_MM16)
                      || ((cfg.depth_encoding == ENC_FLOAT32)
                          && (depth_word[30:23] != F32_EXP_INF)));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
            cph_reg <= '0;
            rph_reg <= '0;
        end
        else if (in_acc)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            cph_reg <= cph_next;
            rph_reg <= rph_next;
        end
    end

    // Hold the captured item until it leaves for the queue or is dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_acc)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_keep_reg  <= keep_in;
            s1_float_reg <= (cfg.depth_encoding == ENC_FLOAT32);
            s1_sign_reg  <= depth_word[31];
            s1_exp_reg   <= depth_word[30:23];
            s1_raw_reg   <= depth_word[15:0];
            s1_m1000_reg <= 34'(mant24) * 34'(MM_PER_M);
            s1_col_reg   <= cur_col;
            s1_row_reg   <= cur_row;
            s1_color_reg <= color_present ? color_rgb : cfg.fallback_rgb;
        end
    end

    // Decode depth to millimetres (16-bit passes through), round float to nearest and saturate
    always_comb
    begin
        shamt   = 6'(F32_EXP_SAT - s1_exp_reg - 8'd1);
        shifted = s1_m1000_reg >> shamt;
        rounded = (35'(shifted) + 35'd1) >> 1;
        if (!s1_float_reg)
        begin
            z_mm = s1_raw_reg;
        end
        else if (s1_sign_reg || (s1_exp_reg == 8'd0) || (s1_exp_reg < F32_EXP_LOW))
        begin
            z_mm = 16'd0;
        end
        else if (s1_exp_reg >= F32_EXP_SAT)
        begin
            z_mm = DEPTH_MAX_MM;
        end
        else
        begin
            z_mm = (rounded > 35'(DEPTH_MAX_MM)) ? DEPTH_MAX_MM : rounded[15:0];
        end
    end

    // Push points, drop the rest
    always_comb
    begin
        s1_point  = s1_keep_reg && (z_mm > DEPTH_MIN_MM);
        push      = s1_valid_reg && s1_point && !qstat.full;
        s1_adv    = s1_valid_reg && (!s1_point || !qstat.full);
        in_ready  = !s1_valid_reg || s1_adv;
        push_data = {s1_color_reg, z_mm, s1_row_reg, s1_col_reg};
    end

endmodule

// ===== src/dtpc_queue.sv =====
// Short point queue between the front and back ends.
module dtpc_queue #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  logic [WIDTH-1:0]        push_data,
    input  logic                    pop,
    output logic [WIDTH-1:0]        pop_data,
    output dtpc_pkg::dtpc_qstat_t   qstat
);
    import dtpc_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [NW-1:0]    count_reg;
    logic             do_push, do_pop;

    always_comb
    begin
        qstat.full  = (count_reg == NW'(DEPTH));
        qstat.empty = (count_reg == '0);
        do_push     = push && !qstat.full;
        do_pop      = pop && !qstat.empty;
        pop_data    = mem_reg[rd_ptr_reg];
    end

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + NW'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - NW'(1);
            end
        end
    end

    // Store the pushed item
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== src/dtpc_back.sv =====
// Back end: pinhole projection through one shared multiplier and the output register.
module dtpc_back #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096,
    localparam int CW = $clog2(MAX_WIDTH),
    localparam int RW = $clog2(MAX_HEIGHT),
    localparam int EW = CW + RW + 40
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  dtpc_pkg::dtpc_cfg_t     cfg,
    input  dtpc_pkg::dtpc_qstat_t   qstat,
    input  logic [EW-1:0]           pop_data,
    output logic                    pop,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [31:0]             point_x_mm,
    output logic [31:0]             point_y_mm,
    output logic [15:0]             point_z_mm,
    output logic [23:0]             point_color
);
    import dtpc_pkg::*;

    localparam int P   = (CW > RW) ? CW : RW;
    localparam int MW  = (P + 4 > 16) ? P + 4 : 16;
    localparam int TW  = MW + 16;
    localparam int HW  = TW - SPLIT_BITS;
    localparam int OA  = (MW > SPLIT_BITS) ? MW : SPLIT_BITS;
    localparam int BW  = 25;
    localparam int PRW = OA + BW;
    localparam int AW  = TW + BW;
    localparam int RXW = (AW - ROUND_SHIFT > 33) ? AW - ROUND_SHIFT : 33;

    dtpc_state_t   state_reg, state_next;
    logic          sel_reg;
    logic [CW-1:0] col_reg;
    logic [RW-1:0] row_reg;
    logic [15:0]   z_reg;
    logic [23:0]   color_reg;
    logic [MW-1:0] mag_reg;
    logic          neg_reg;
    logic [PRW-1:0] prod_reg;
    logic [HW-1:0] hi_reg;
    logic [AW-1:0] acc_reg;
    logic [31:0]   x_reg;
    logic          out_valid_reg;
    logic [31:0]   out_x_reg, out_y_reg;
    logic [15:0]   out_z_reg;
    logic [23:0]   out_color_reg;

    logic          out_free;
    logic          ld_work, ld_mag, ld_prod, ld_hi, acc_init, acc_add;
    logic          fin_x, fin_y;
    logic [OA-1:0] mul_a;
    logic [BW-1:0] mul_b, inv_sel;
    logic [P-1:0]  pos_sel;
    logic [MW:0]   p16, cen, diff;
    logic          neg_c;
    logic [RXW-1:0] r_ext;
    logic [31:0]   res;

    assign out_free = !out_valid_reg || out_ready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: state_next = qstat.empty ? ST_IDLE : ST_MAG;
            ST_MAG:  state_next = ST_MZ;
            ST_MZ:   state_next = ST_PL;
            ST_PL:   state_next = ST_PH;
            ST_PH:   state_next = ST_SUM;
            ST_SUM:  state_next = ST_FIN;
            ST_FIN:
            begin
                if (!sel_reg)
                begin
                    state_next = ST_MAG;
                end
                else if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        pop      = 1'b0;
        ld_work  = 1'b0;
        ld_mag   = 1'b0;
        ld_prod  = 1'b0;
        ld_hi    = 1'b0;
        acc_init = 1'b0;
        acc_add  = 1'b0;
        fin_x    = 1'b0;
        fin_y    = 1'b0;
        mul_a    = OA'(mag_reg);
        mul_b    = BW'(z_reg);
        case (state_reg)
            ST_IDLE:
            begin
                pop     = !qstat.empty;
                ld_work = !qstat.empty;
            end
            ST_MAG: ld_mag = 1'b1;
            ST_MZ:  ld_prod = 1'b1;
            ST_PL:
            begin
                ld_prod = 1'b1;
                ld_hi   = 1'b1;
                mul_a   = OA'(prod_reg[SPLIT_BITS-1:0]);
                mul_b   = inv_sel;
            end
            ST_PH:
            begin
                ld_prod  = 1'b1;
                acc_init = 1'b1;
                mul_a    = OA'(hi_reg);
                mul_b    = inv_sel;
            end
            ST_SUM: acc_add = 1'b1;
            ST_FIN:
            begin
                fin_x = !sel_reg;
                fin_y = sel_reg && out_free;
            end
            default: ;
        endcase
    end

    // Signed offset from the principal point, Q.4 pixels
    always_comb
    begin
        inv_sel = sel_reg ? cfg.inv_focal_y : cfg.inv_focal_x;
        pos_sel = sel_reg ? P'(row_reg) : P'(col_reg);
        p16     = (MW + 1)'({pos_sel, 4'b0000});
        cen     = (MW + 1)'(sel_reg ? cfg.center_y : cfg.center_x);
        neg_c   = (p16 < cen);
        diff    = neg_c ? (cen - p16) : (p16 - cen);
    end

    // Drop rounding bits, restore sign and saturate
    always_comb
    begin
        r_ext = RXW'(acc_reg >> ROUND_SHIFT);
        if (neg_reg)
        begin
            res = (r_ext > RXW'(33'h080000000)) ? 32'h80000000 : (32'd0 - r_ext[31:0]);
        end
        else
        begin
            res = (r_ext > RXW'(33'h07FFFFFFF)) ? 32'h7FFFFFFF : r_ext[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sel_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (ld_work)
            begin
                sel_reg <= 1'b0;
            end
            else if (fin_x)
            begin
                sel_reg <= 1'b1;
            end
            if (fin_y)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Work and datapath registers
    always_ff @(posedge clk)
    begin
        if (ld_work)
        begin
            col_reg   <= pop_data[CW-1:0];
            row_reg   <= pop_data[CW+RW-1:CW];
            z_reg     <= pop_data[CW+RW+15:CW+RW];
            color_reg <= pop_data[EW-1:CW+RW+16];
        end
        if (ld_mag)
        begin
            mag_reg <= diff[MW-1:0];
            neg_reg <= neg_c;
        end
        if (ld_prod)
        begin
            prod_reg <= PRW'(mul_a) * PRW'(mul_b);
        end
        if (ld_hi)
        begin
            hi_reg <= prod_reg[TW-1:SPLIT_BITS];
        end
        if (acc_init)
        begin
            acc_reg <= AW'(prod_reg) + (AW'(1) << (ROUND_SHIFT - 1));
        end
        else if (acc_add)
        begin
            acc_reg <= acc_reg + (AW'(prod_reg) << SPLIT_BITS);
        end
        if (fin_x)
        begin
            x_reg <= res;
        end
        if (fin_y)
        begin
            out_x_reg     <= x_reg;
            out_y_reg     <= res;
            out_z_reg     <= z_reg;
            out_color_reg <= color_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign point_x_mm  = out_x_reg;
    assign point_y_mm  = out_y_reg;
    assign point_z_mm  = out_z_reg;
    assign point_color = out_color_reg;

endmodule

// ===== src/dtpc_checker.sv =====
// Port-level checker of the depth to point cloud block and its bind.
module dtpc_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 m_tvalid,
    input logic                                 m_tready,
    input logic [dtpc_pkg::OUT_TDATA_W-1:0]     m_tdata,
    input logic                                 cfg_valid,
    input logic                                 cfg_ready
);
    import dtpc_pkg::*;

    // Hold a stalled result item
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result item withdrawn while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result item changed while stalled");

    // Every point lies beyond the shallow-depth cut-off
    a_depth_floor: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[79:64] > DEPTH_MIN_MM))
        else $error("point depth at or below cut-off");

    // Configuration writes are never back-pressured
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write stalled");

endmodule

bind depth_to_point_cloud dtpc_checker u_dtpc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);

// ===== bench/tb.sv =====
// Self-checking bench for depth_to_point_cloud: point predictor class, stream drivers and top.
module tb;
    import dtpc_pkg::*;

    localparam int MAX_COLUMNS   = 4096;
    localparam int MAX_ROWS      = 4096;
    localparam int SETTLE_CYCLES = 40;

    // Encodings that the block accepts but turns into no points
    localparam logic [1:0] ENC_UNSUPPORTED = 2'd2;
    localparam logic [1:0] ENC_RESERVED    = 2'd3;

    // One point as it sits on m_tdata, x in the lowest bits
    typedef struct packed {
        logic [23:0] color;
        logic [15:0] z;
        logic [31:0] y;
        logic [31:0] x;
    } point_t;

    class point_scoreboard;
        dtpc_cfg_t   regs;
        int unsigned col;
        int unsigned row;
        int unsigned col_phase;
        int unsigned row_phase;
        point_t      expected_q[$];
        int          errors;
        int          pixels;
        int          points;

        function new();
            regs      = CFG_RESET;
            col       = 0;
            row       = 0;
            col_phase = 0;
            row_phase = 0;
            errors    = 0;
            pixels    = 0;
            points    = 0;
        endfunction

        // Print one line per mismatch and count it
        task report_mismatch(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        function void write_reg(dtpc_reg_t idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_IMAGE_WIDTH:    regs.image_width    = val[12:0];
                REG_DECIMATION:     regs.decimation     = val[7:0];
                REG_DEPTH_ENCODING: regs.depth_encoding = val[1:0];
                REG_CENTER_X:       regs.center_x       = val[15:0];
                REG_CENTER_Y:       regs.center_y       = val[15:0];
                REG_INV_FOCAL_X:    regs.inv_focal_x    = val[24:0];
                REG_INV_FOCAL_Y:    regs.inv_focal_y    = val[24:0];
                REG_FALLBACK_RGB:   regs.fallback_rgb   = val[23:0];
                default: ;
            endcase
        endfunction

        // Float32 metres to millimetres, round half up, saturate; false for NaN and Inf
        function bit decode_float_mm(logic [31:0] w, output logic [15:0] mm);
            logic [7:0]  ex;
            logic [63:0] mant;
            logic [63:0] val;
            int          sh;
            ex   = w[30:23];
            mant = 64'(w[22:0]);
            mm   = '0;
            if (ex == F32_EXP_INF)
                return 1'b0;
            if (w[31])
                return 1'b1;
            if (ex != 8'd0)
            begin
                mant[23] = 1'b1;
                sh = int'(ex);
                sh = sh - 150;
            end
            else
                sh = -149;
            mant = mant * 64'd1000;
            if (sh > 20)
                val = 64'd65536;
            else if (sh >= 0)
                val = mant << sh;
            else if (-sh > 40)
                val = 64'd0;
            else
                val = (mant + (64'd1 << (-sh - 1))) >> (-sh);
            mm = (val > 64'd65535) ? DEPTH_MAX_MM : val[15:0];
            return 1'b1;
        endfunction

        // Signed offset from the principal point times z times 1/f, rounded half away from zero
        function logic [31:0] project_axis(int unsigned pos, logic [15:0] centre,
                                           logic [15:0] z, logic [24:0] inv);
            logic [63:0] p16;
            logic [63:0] c64;
            logic [63:0] mag;
            logic [63:0] prod;
            logic [63:0] r;
            logic        neg;
            p16  = 64'(pos);
            p16  = p16 << 4;
            c64  = 64'(centre);
            neg  = p16 < c64;
            mag  = neg ? c64 - p16 : p16 - c64;
            prod = mag * 64'(z) * 64'(inv);
            r    = (prod + (64'd1 << (ROUND_SHIFT - 1))) >> ROUND_SHIFT;
            if (neg)
            begin
                if (r > 64'h8000_0000)
                    r = 64'h8000_0000;
                return 32'd0 - r[31:0];
            end
            if (r > 64'h7FFF_FFFF)
                r = 64'h7FFF_FFFF;
            return r[31:0];
        endfunction

        // Predict the point of one accepted pixel, then advance the raster position
        function void note_pixel(logic [31:0] word, logic [23:0] rgb, logic present,
                                 logic start);
            int unsigned keep_every;
            int unsigned w;
            logic [15:0] z;
            logic        ok;
            point_t      pt;
            keep_every = (regs.decimation == 8'd0) ? 1 : 32'(regs.decimation);
            w = (regs.image_width == 13'd0) ? 1 : 32'(regs.image_width);
            if (w > MAX_COLUMNS)
                w = MAX_COLUMNS;
            pixels++;
            if (start)
            begin
                col       = 0;
                row       = 0;
                col_phase = 0;
                row_phase = 0;
            end
            if (col_phase == 0 && row_phase == 0 &&
                regs.inv_focal_x != 25'd0 && regs.inv_focal_y != 25'd0)
            begin
                z  = '0;
                ok = 1'b0;
                if (regs.depth_encoding == ENC_MM16)
                begin
                    z  = word[15:0];
                    ok = 1'b1;
                end
                else if (regs.depth_encoding == ENC_FLOAT32)
                    ok = decode_float_mm(word, z);
                if (ok && z > DEPTH_MIN_MM)
                begin
                    pt.x     = project_axis(col, regs.center_x, z, regs.inv_focal_x);
                    pt.y     = project_axis(row, regs.center_y, z, regs.inv_focal_y);
                    pt.z     = z;
                    pt.color = present ? rgb : regs.fallback_rgb;
                    expected_q.insert(expected_q.size(), pt);
                end
            end
            if (col + 1 >= w)
            begin
                col       = 0;
                col_phase = 0;
                row       = (row + 1 >= MAX_ROWS) ? 0 : row + 1;
                row_phase = (row_phase + 1 >= keep_every) ? 0 : row_phase + 1;
            end
            else
            begin
                col++;
                col_phase = (col_phase + 1 >= keep_every) ? 0 : col_phase + 1;
            end
        endfunction

        // Compare one delivered point with the oldest prediction
        task check_point(logic [OUT_TDATA_W-1:0] data);
            point_t got;
            point_t want;
            got = data;
            points++;
            if (expected_q.size() == 0)
            begin
                report_mismatch($sformatf("point %0d arrived with none pending: %h",
                                          points, data));
                return;
            end
            want = expected_q.pop_front();
            if (got.x !== want.x)
                report_mismatch($sformatf("point %0d x %0d, predicted %0d",
                                          points, $signed(got.x), $signed(want.x)));
            if (got.y !== want.y)
                report_mismatch($sformatf("point %0d y %0d, predicted %0d",
                                          points, $signed(got.y), $signed(want.y)));
            if (got.z !== want.z)
                report_mismatch($sformatf("point %0d z %0d, predicted %0d",
                                          points, got.z, want.z));
            if (got.color !== want.color)
                report_mismatch($sformatf("point %0d colour %h, predicted %h",
                                          points, got.color, want.color));
        endtask
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;   // depth_word, color_rgb
    logic [IN_TUSER_W-1:0]  s_tuser;   // color_present, frame_start
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;   // point_x_mm, point_y_mm, point_z_mm, point_color
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    point_scoreboard sb;
    int              send_idle_pct;
    int              recv_idle_pct;
    int              settings_applied;

    depth_to_point_cloud #(
        .MAX_WIDTH  (MAX_COLUMNS),
        .MAX_HEIGHT (MAX_ROWS)
    ) dut (.*);

    always #1 clk = ~clk;

    // Give up on a hung run
    initial
    begin
        #2_000_000;
        $display("tb: errors");
        $finish;
    end

    // Check each delivered point and pick the next ready level
    initial
    begin
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                sb.check_point(m_tdata);
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Offer one pixel, hold it until taken, then idle cycle by cycle at the sender rate
    task automatic send_pixel(logic [31:0] word, logic [23:0] rgb, logic present, logic start);
        s_tvalid <= 1'b1;
        s_tdata  <= {rgb, word};
        s_tuser  <= {start, present};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_pixel(word, rgb, present, start);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic cfg_write(dtpc_reg_t idx, logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.write_reg(idx, val);
    endtask

    task automatic apply_settings(dtpc_cfg_t c);
        cfg_write(REG_IMAGE_WIDTH, CFG_DATA_W'(c.image_width));
        cfg_write(REG_DECIMATION, CFG_DATA_W'(c.decimation));
        cfg_write(REG_DEPTH_ENCODING, CFG_DATA_W'(c.depth_encoding));
        cfg_write(REG_CENTER_X, CFG_DATA_W'(c.center_x));
        cfg_write(REG_CENTER_Y, CFG_DATA_W'(c.center_y));
        cfg_write(REG_INV_FOCAL_X, c.inv_focal_x);
        cfg_write(REG_INV_FOCAL_Y, c.inv_focal_y);
        cfg_write(REG_FALLBACK_RGB, CFG_DATA_W'(c.fallback_rgb));
        cfg_valid <= 1'b0;
        settings_applied++;
    endtask

    // Stop sending until every predicted point has come out
    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
    endtask

    // Drain, then let pixels that give no point clear the front end
    task automatic quiesce();
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic dtpc_cfg_t random_settings();
        dtpc_cfg_t c;
        case ($urandom_range(9))
            0:       c.image_width = 13'd0;
            1:       c.image_width = 13'd1;
            2:       c.image_width = 13'd4096;
            3:       c.image_width = 13'($urandom_range(4097, 8191));
            default: c.image_width = 13'($urandom_range(2, 24));
        endcase
        case ($urandom_range(7))
            0:       c.decimation = 8'd0;
            1:       c.decimation = 8'd255;
            2:       c.decimation = 8'($urandom);
            default: c.decimation = 8'($urandom_range(1, 4));
        endcase
        case ($urandom_range(9))
            0:             c.depth_encoding = ENC_UNSUPPORTED;
            1:             c.depth_encoding = ENC_RESERVED;
            2, 3, 4, 5:    c.depth_encoding = ENC_MM16;
            default:       c.depth_encoding = ENC_FLOAT32;
        endcase
        case ($urandom_range(5))
            0:       c.center_x = 16'd0;
            1:       c.center_x = 16'hFFFF;
            default: c.center_x = 16'($urandom);
        endcase
        case ($urandom_range(5))
            0:       c.center_y = 16'd0;
            1:       c.center_y = 16'hFFFF;
            default: c.center_y = 16'($urandom);
        endcase
        case ($urandom_range(11))
            0:       c.inv_focal_x = 25'd0;
            1:       c.inv_focal_x = 25'h100_0000;
            2:       c.inv_focal_x = 25'h1FF_FFFF;
            default: c.inv_focal_x = 25'($urandom_range(1, 32'h100_0000));
        endcase
        case ($urandom_range(11))
            0:       c.inv_focal_y = 25'd0;
            1:       c.inv_focal_y = 25'h100_0000;
            2:       c.inv_focal_y = 25'h1FF_FFFF;
            default: c.inv_focal_y = 25'($urandom_range(1, 32'h100_0000));
        endcase
        case ($urandom_range(5))
            0:       c.fallback_rgb = 24'h000000;
            1:       c.fallback_rgb = 24'hFFFFFF;
            default: c.fallback_rgb = 24'($urandom);
        endcase
        return c;
    endfunction

    // Mostly plausible depths, with shallow, saturating and non-finite words mixed in
    function automatic logic [31:0] random_depth(logic [1:0] enc);
        logic [31:0] w;
        w = $urandom;
        if (enc == ENC_FLOAT32)
        begin
            case ($urandom_range(19))
                0:       w[30:23] = F32_EXP_INF;
                1:       w[31] = 1'b1;
                2:       w[30:23] = 8'd0;
                3:       ;
                default:
                begin
                    w[31]    = 1'b0;
                    w[30:23] = 8'($urandom_range(117, 134));
                end
            endcase
        end
        else
        begin
            case ($urandom_range(9))
                0:       w[15:0] = 16'($urandom_range(0, 12));
                1:       w[15:0] = DEPTH_MAX_MM;
                default: ;
            endcase
        end
        return w;
    endfunction

    task automatic run_directed();
        dtpc_cfg_t c;
        c                = CFG_RESET;
        c.image_width    = 13'd4;
        c.decimation     = 8'd1;
        c.depth_encoding = ENC_MM16;
        c.center_x       = 16'd0;
        c.center_y       = 16'hFFFF;
        c.inv_focal_x    = 25'h100_0000;
        c.inv_focal_y    = 25'h1FF_FFFF;
        c.fallback_rgb   = 24'h000000;
        apply_settings(c);
        // 16-bit depth: deepest, shallowest kept, at the cut-off, row end, zero
        send_pixel(32'h0000_FFFF, 24'hFFFFFF, 1'b1, 1'b1);
        send_pixel(32'hFFFF_000B, 24'h000000, 1'b1, 1'b0);
        send_pixel(32'h0000_000A, 24'h123456, 1'b1, 1'b0);
        send_pixel(32'hFFFF_FFFF, 24'hABCDEF, 1'b0, 1'b0);
        send_pixel(32'hFFFF_0000, 24'hFFFFFF, 1'b1, 1'b0);
        send_pixel(32'h0000_8000, 24'h5A5A5A, 1'b0, 1'b0);

        // Float metres: zeros, negatives, non-finite, rounding tie, cut-off, saturation
        quiesce();
        c.depth_encoding = ENC_FLOAT32;
        c.image_width    = 13'd3;
        c.decimation     = 8'd0;
        c.center_x       = 16'hFFFF;
        c.center_y       = 16'd0;
        c.fallback_rgb   = 24'hFFFFFF;
        apply_settings(c);
        send_pixel(32'h0000_0000, 24'h010203, 1'b1, 1'b1);
        send_pixel(32'h8000_0000, 24'h010203, 1'b1, 1'b0);
        send_pixel(32'hBF80_0000, 24'h010203, 1'b1, 1'b0);
        send_pixel(32'h7FC0_0000, 24'h010203, 1'b1, 1'b0);
        send_pixel(32'h7F80_0000, 24'h010203, 1'b1, 1'b0);
        send_pixel(32'hFF80_0000, 24'h010203, 1'b1, 1'b0);
        send_pixel(32'h3F80_0000, 24'hC0FFEE, 1'b1, 1'b0);
        send_pixel(32'h3F30_0000, 24'h00FF00, 1'b0, 1'b0);
        send_pixel(32'h3C23_D70A, 24'h0000FF, 1'b1, 1'b0);
        send_pixel(32'h42C8_0000, 24'hFF0000, 1'b1, 1'b0);
        send_pixel(32'h7F7F_FFFF, 24'h808080, 1'b0, 1'b0);
        send_pixel(32'h0000_0001, 24'h7F7F7F, 1'b1, 1'b0);

        // Encodings with no decoder give nothing
        quiesce();
        c.depth_encoding = ENC_UNSUPPORTED;
        apply_settings(c);
        send_pixel(32'h0000_1000, 24'h111111, 1'b1, 1'b1);
        send_pixel(32'h3F80_0000, 24'h222222, 1'b0, 1'b0);
        quiesce();
        c.depth_encoding = ENC_RESERVED;
        apply_settings(c);
        send_pixel(32'h0000_1000, 24'h333333, 1'b1, 1'b1);
    endtask

    task automatic run_random();
        dtpc_cfg_t c;
        int        phase_no;
        int        n;
        int        frame_len;
        int        frame_pos;
        logic      start;
        for (phase_no = 0; phase_no < 15; phase_no++)
        begin
            if (phase_no < 5)
            begin
                send_idle_pct = 27;
                recv_idle_pct = 46;
            end
            else if (phase_no < 10)
            begin
                send_idle_pct = 46;
                recv_idle_pct = 27;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            c = random_settings();
            // Force the width and decimation extremes early on
            case (phase_no)
                1:
                begin
                    c.image_width = 13'd4096;
                    c.decimation  = 8'd255;
                end
                2:
                begin
                    c.image_width = 13'd0;
                    c.decimation  = 8'd0;
                end
                3:       c.image_width = 13'h1FFF;
                4:       c.image_width = 13'd1;
                default: ;
            endcase
            quiesce();
            apply_settings(c);
            frame_len = (c.image_width == 13'd0) ? 1 :
                        (c.image_width > MAX_COLUMNS) ? MAX_COLUMNS : int'(c.image_width);
            frame_len = frame_len * $urandom_range(2, 6);
            // Usually open a new frame; otherwise carry on mid-frame under new settings
            frame_pos = ($urandom_range(3) == 0) ? 1 : 0;
            for (n = 0; n < 120; n++)
            begin
                if (phase_no == 6 && n == 60)
                    hold_until_drained();
                start = (frame_pos == 0) || ($urandom_range(49) == 0);
                send_pixel(random_depth(c.depth_encoding), 24'($urandom),
                           ($urandom_range(3) != 0), start);
                frame_pos = start ? 1 : frame_pos + 1;
                if (frame_pos >= frame_len)
                    frame_pos = 0;
            end
        end
    endtask

    initial
    begin
        sb               = new();
        rst_n            = 1'b0;
        s_tvalid         = 1'b0;
        s_tdata          = '0;
        s_tuser          = '0;
        m_tready         = 1'b0;
        cfg_valid        = 1'b0;
        cfg_index        = '0;
        cfg_data         = '0;
        send_idle_pct    = 27;
        recv_idle_pct    = 46;
        settings_applied = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        run_random();

        // Wait for the tail, then look for stragglers
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.expected_q.size() != 0)
            sb.report_mismatch($sformatf("%0d predicted points never came out",
                                         sb.expected_q.size()));
        $display("summary: %0d pixels sent, %0d points checked, %0d register settings",
                 sb.pixels, sb.points, settings_applied);
        $display("summary: 16-bit, float and unsupported depth, decimation, frames, stalls");
        if (sb.errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end
endmodule
